>>> hdl/wrm_pkg.sv
// Shared constants for the weighted running mean block.
// No dependencies; used by wrm_front, wrm_back, the top level and the testbench.
`default_nettype none
package wrm_pkg;
    localparam int SAMPLE_WIDTH_DEF  = 16;
    localparam int FRACTION_BITS_DEF = 8;
    localparam int ACCUM_WIDTH_DEF   = 64;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NEGW = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;
    localparam logic [1:0] ST_SAT  = 2'd3;
endpackage
`default_nettype wire

>>> hdl/wrm_front.sv
// Front end: accumulates the weighted sums and classifies each beat.
// Uses wrm_pkg. Emits a command (status, sum, total, mode) into the job queue.
`default_nettype none
module wrm_front #(
    parameter int SW = wrm_pkg::SAMPLE_WIDTH_DEF,
    parameter int AW = wrm_pkg::ACCUM_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_mode,
    input  wire logic                 i_valid,
    input  wire logic signed [SW-1:0] i_value,
    input  wire logic signed [SW-1:0] i_weight,
    output logic                      o_busy,
    input  wire logic                 i_q_full,
    output logic                      o_q_push,
    output logic [1:0]                o_q_status,
    output logic                      o_q_mode,
    output logic signed [AW-1:0]      o_q_sum,
    output logic [AW-1:0]             o_q_total
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001, S_MUL1 = 4'b0010, S_MUL2 = 4'b0100, S_ADD = 4'b1000
    } t_fstate;

    localparam int PW = 3 * SW;
    localparam logic signed [AW-1:0] AMAX = {1'b0, {(AW-1){1'b1}}};
    localparam logic signed [AW-1:0] AMIN = {1'b1, {(AW-1){1'b0}}};

    t_fstate r_st, n_st;
    logic signed [AW-1:0] r_sum, r_tot;
    logic [SW-1:0] r_vmag, r_wmag;
    logic r_vneg, r_mode;
    logic [PW-1:0] r_prod;
    logic r_push;
    logic [1:0] r_status;

    logic [SW-1:0] w_vmag, w_wmag;
    assign w_vmag = i_value[SW-1] ? SW'(-i_value) : SW'(i_value);
    assign w_wmag = SW'(i_weight);

    // Wide accumulate with saturation; the product fits in PW bits, so clamp to AW.
    logic [AW:0] w_pmag;
    logic signed [AW+1:0] w_sum_x, w_tot_x;
    logic signed [AW-1:0] w_sum_n, w_tot_n;
    always_comb begin
        if (PW > AW && (r_prod >> AW) != '0) w_pmag = {1'b0, {AW{1'b1}}};
        else w_pmag = (AW+1)'(r_prod);
        if (r_vneg && !r_mode) w_sum_x = (AW+2)'(r_sum) - (AW+2)'(w_pmag);
        else w_sum_x = (AW+2)'(r_sum) + (AW+2)'(w_pmag);
        if (w_sum_x >= (AW+2)'(AMAX)) w_sum_n = AMAX;
        else if (w_sum_x <= (AW+2)'(AMIN)) w_sum_n = AMIN;
        else w_sum_n = AW'(w_sum_x);
        w_tot_x = (AW+2)'(r_tot) + (AW+2)'($unsigned(r_wmag));
        if (w_tot_x >= (AW+2)'(AMAX)) w_tot_n = AMAX;
        else w_tot_n = AW'(w_tot_x);
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE: if (i_valid && !i_weight[SW-1]) n_st = S_MUL1;
            S_MUL1: n_st = r_mode ? S_MUL2 : S_ADD;
            S_MUL2: n_st = S_ADD;
            S_ADD:  n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_sum <= '0; r_tot <= '0; r_push <= 1'b0;
        end else begin
            r_st <= n_st;
            r_push <= 1'b0;
            if (r_st == S_IDLE && i_valid) begin
                r_vmag <= w_vmag; r_wmag <= w_wmag;
                r_vneg <= i_value[SW-1]; r_mode <= i_mode;
                if (i_weight[SW-1]) begin
                    r_status <= wrm_pkg::ST_NEGW; r_push <= 1'b1;
                end
            end
            if (r_st == S_MUL1) begin
                if (r_mode) r_prod <= PW'(r_vmag) * PW'(r_vmag);
                else        r_prod <= PW'(r_vmag) * PW'(r_wmag);
            end
            if (r_st == S_MUL2) r_prod <= PW'(r_prod[2*SW-1:0]) * PW'(r_wmag);
            if (r_st == S_ADD) begin
                r_sum <= w_sum_n; r_tot <= w_tot_n; r_push <= 1'b1;
                if (w_sum_n == AMAX || w_sum_n == AMIN || w_tot_n == AMAX)
                    r_status <= wrm_pkg::ST_SAT;
                else if (w_tot_n <= 0) r_status <= wrm_pkg::ST_ZERO;
                else r_status <= wrm_pkg::ST_OK;
            end
        end
    end

    // A beat enters only when the queue can absorb its command.
    assign o_busy     = (r_st != S_IDLE) || r_push || i_q_full;
    assign o_q_push   = r_push;
    assign o_q_status = r_status;
    assign o_q_mode   = r_mode;
    assign o_q_sum    = r_sum;
    assign o_q_total  = r_tot;
endmodule
`default_nettype wire

>>> hdl/wrm_queue.sv
// Two-entry job queue between the front end and the divide/root back end.
// Uses wrm_pkg constants only through its parent's parameters.
`default_nettype none
module wrm_queue #(
    parameter int DW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire logic [DW-1:0] i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_empty,
    output logic [DW-1:0]      o_data
);
    logic [DW-1:0] r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
    assign o_data  = r_mem[r_rp];
    assign o_full  = r_cnt[1];
    assign o_empty = (r_cnt == 2'd0);
endmodule
`default_nettype wire

>>> hdl/wrm_back.sv
// Back end: radix-2 divide of |sum| by total, then in quadratic mode a two-bit-per-step square root.
// Uses wrm_pkg status codes; result held in an output register until popped.
`default_nettype none
module wrm_back #(
    parameter int SW = wrm_pkg::SAMPLE_WIDTH_DEF,
    parameter int AW = wrm_pkg::ACCUM_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_q_empty,
    output logic                      o_q_pop,
    input  wire logic [1:0]           i_status,
    input  wire logic                 i_mode,
    input  wire logic signed [AW-1:0] i_sum,
    input  wire logic [AW-1:0]        i_total,
    output logic                      o_empty,
    input  wire logic                 i_pop,
    output logic signed [SW:0]        o_mean,
    output logic [1:0]                o_status
);
    typedef enum logic [3:0] {
        B_IDLE = 4'b0001, B_DIV = 4'b0010, B_SQRT = 4'b0100, B_DONE = 4'b1000
    } t_bstate;
    localparam int CW = $clog2(AW + 1);
    localparam logic [AW-1:0] LIMIT = AW'(1) << (SW - 1);

    t_bstate r_st;
    logic [AW-1:0] r_rem, r_quo, r_den, r_root, r_bit;
    logic [CW-1:0] r_cnt;
    logic r_neg, r_mode, r_full;
    logic signed [SW:0] r_mean;
    logic [1:0] r_status;

    logic [AW:0] w_trial;
    logic [AW-1:0] w_rb;
    assign w_trial = {r_rem, r_quo[AW-1]} - {1'b0, r_den};
    assign w_rb    = r_root + r_bit;

    logic [AW-1:0] w_q;
    always_comb begin
        w_q = (r_quo > LIMIT) ? LIMIT : r_quo;
    end

    assign o_q_pop = (r_st == B_IDLE) && !i_q_empty && !r_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= B_IDLE; r_full <= 1'b0;
        end else begin
            if (r_full && i_pop) r_full <= 1'b0;
            unique case (r_st)
                B_IDLE: if (o_q_pop) begin
                    r_mode <= i_mode;
                    if (i_status != wrm_pkg::ST_OK) begin
                        r_status <= i_status; r_mean <= '0; r_full <= 1'b1;
                    end else begin
                        r_neg <= i_sum[AW-1];
                        r_quo <= i_sum[AW-1] ? AW'(-i_sum) : AW'(i_sum);
                        r_den <= i_total; r_rem <= '0; r_cnt <= CW'(AW);
                        r_st <= B_DIV;
                    end
                end
                B_DIV: begin
                    if (!w_trial[AW]) begin
                        r_rem <= AW'(w_trial); r_quo <= {r_quo[AW-2:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[AW-2:0], r_quo[AW-1]};
                        r_quo <= {r_quo[AW-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) begin
                        if (r_mode) begin
                            r_st <= B_SQRT; r_root <= '0;
                            r_bit <= AW'(1) << (AW - 2);
                        end else r_st <= B_DONE;
                    end
                end
                B_SQRT: begin
                    // Quotient register doubles as the remainder of the root.
                    if (r_quo >= w_rb) begin
                        r_quo <= r_quo - w_rb; r_root <= (r_root >> 1) + r_bit;
                    end else r_root <= r_root >> 1;
                    r_bit <= r_bit >> 2;
                    if (r_bit == AW'(1)) r_st <= B_DONE;
                end
                B_DONE: if (!r_full) begin
                    logic [AW-1:0] v;
                    v = r_mode ? (r_neg ? '0 : ((r_root > LIMIT) ? LIMIT : r_root)) : w_q;
                    r_mean <= (!r_mode && r_neg) ? -(SW+1)'(v) : (SW+1)'(v);
                    r_status <= wrm_pkg::ST_OK; r_full <= 1'b1; r_st <= B_IDLE;
                end
                default: r_st <= B_IDLE;
            endcase
        end
    end
    assign o_empty  = !r_full;
    assign o_mean   = r_mean;
    assign o_status = r_status;
endmodule
`default_nettype wire

>>> hdl/weighted_running_mean.sv
// Top level of the weighted running mean block: front end, job queue, back end.
// Depends on wrm_pkg, wrm_front, wrm_queue and wrm_back.
//
//  channel  | handshake        | beat payload
//  input    | push / full      | i_sample_value, i_sample_weight
//  result   | empty / pop      | o_running_mean, o_mean_status
//  config   | i_cfg_we         | i_cfg_data (mean_mode)
//
// A beat passes the front end through a multiply and a saturating add in arithmetic
// mode; quadratic mode needs a second multiply before the saturating add. The back
// end then runs the shift-subtract divide, followed by the root in quadratic mode;
// the divider sets the rate. Negative-weight beats skip the back end's arithmetic.
// Reset clears both sums. A stalled result holds the back end, which fills the
// queue and raises full.
`default_nettype none
module weighted_running_mean #(
    parameter int SAMPLE_WIDTH  = wrm_pkg::SAMPLE_WIDTH_DEF,
    parameter int ACCUM_WIDTH   = wrm_pkg::ACCUM_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic                         i_cfg_data,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample_value,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample_weight,
    output logic                              empty,
    input  wire logic                         pop,
    output logic signed [SAMPLE_WIDTH:0]      o_running_mean,
    output logic [1:0]                        o_mean_status
);
    localparam int AW = ACCUM_WIDTH;
    localparam int QW = 3 + 2 * AW;
    // Fraction alignment is implicit: products and sums keep their native scaling,
    // and the divide and root bring the result back to the sample's fraction bits.

    logic r_mode;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_mode <= 1'b0;
        else if (i_cfg_we) r_mode <= i_cfg_data;
    end

    logic busy, fq_push, q_full, q_empty, q_pop, f_mode;
    logic [1:0] f_status;
    logic signed [AW-1:0] f_sum;
    logic [AW-1:0] f_tot;
    logic [QW-1:0] q_in, q_out;

    assign full = busy;

    wrm_front #(.SW(SAMPLE_WIDTH), .AW(AW)) u_front (
        .i_clk, .i_rst_n, .i_mode(r_mode), .i_valid(push && !full),
        .i_value(i_sample_value), .i_weight(i_sample_weight), .o_busy(busy),
        .i_q_full(q_full), .o_q_push(fq_push), .o_q_status(f_status),
        .o_q_mode(f_mode), .o_q_sum(f_sum), .o_q_total(f_tot)
    );

    assign q_in = {f_status, f_mode, f_sum, f_tot};
    wrm_queue #(.DW(QW)) u_queue (
        .i_clk, .i_rst_n, .i_push(fq_push), .i_data(q_in), .o_full(q_full),
        .i_pop(q_pop), .o_empty(q_empty), .o_data(q_out)
    );

    wrm_back #(.SW(SAMPLE_WIDTH), .AW(AW)) u_back (
        .i_clk, .i_rst_n, .i_q_empty(q_empty), .o_q_pop(q_pop),
        .i_status(q_out[QW-1 -: 2]), .i_mode(q_out[2*AW]),
        .i_sum(q_out[2*AW-1 -: AW]), .i_total(q_out[AW-1:0]),
        .o_empty(empty), .i_pop(pop), .o_mean(o_running_mean),
        .o_status(o_mean_status)
    );

`ifndef NO_ASSERTIONS
    a_nopush_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !fq_push) else $error("queue overrun");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_mean_status != wrm_pkg::ST_OK) |-> o_running_mean == '0)
        else $error("nonzero mean with error status");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_running_mean)))
        else $error("result changed while waiting");
`endif
endmodule
`default_nettype wire

>>> verif/weighted_running_mean_tb.sv
// Self-checking testbench for weighted_running_mean: directed and random beats in both modes.
// Depends on wrm_pkg and the weighted_running_mean RTL; a scoreboard class predicts results.
`default_nettype none
module weighted_running_mean_tb;

    typedef struct packed {
        logic signed [16:0] mean;
        logic [1:0]         status;
    } t_mean_result;

    localparam longint ACC_TOP = 64'sh7fff_ffff_ffff_ffff;
    localparam longint ACC_BOT = 64'sh8000_0000_0000_0000;
    localparam int     IDLE_LIMIT = 5000;
    localparam int     DRAIN_WAIT = 150;

    class t_mean_scoreboard;
        logic         mode;
        longint       wsum;
        longint       wtotal;
        t_mean_result pending[$];
        int           errors;
        int           checked;
        int           status_seen[4];

        function new();
            mode = 1'b0;
            wsum = 0;
            wtotal = 0;
            errors = 0;
            checked = 0;
        endfunction

        function longint sat_sum(longint acc, longint term);
            logic signed [65:0] s;
            s = acc;
            s = s + term;
            if (s >= ACC_TOP) return ACC_TOP;
            if (s <= ACC_BOT) return ACC_BOT;
            return s[63:0];
        endfunction

        function longint unsigned int_root(longint unsigned x);
            longint unsigned root, bitv;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > x) bitv >>= 2;
            while (bitv != 0) begin
                if (x >= root + bitv) begin
                    x = x - (root + bitv);
                    root = (root >> 1) + bitv;
                end else begin
                    root >>= 1;
                end
                bitv >>= 2;
            end
            return root;
        endfunction

        function void note_input(logic signed [15:0] v, logic signed [15:0] w);
            t_mean_result     r;
            longint           vm, wm, term;
            longint unsigned  q, smag;
            logic             sneg;
            r.mean = '0;
            if (w < 0) begin
                r.status = wrm_pkg::ST_NEGW;
                pending.push_back(r);
                return;
            end
            vm = (v < 0) ? -longint'(v) : longint'(v);
            wm = longint'(w);
            if (mode) term = vm * vm * wm;
            else term = (v < 0) ? -(vm * wm) : vm * wm;
            wsum = sat_sum(wsum, term);
            wtotal = sat_sum(wtotal, wm);
            if (wsum == ACC_TOP || wsum == ACC_BOT || wtotal == ACC_TOP)
                r.status = wrm_pkg::ST_SAT;
            else if (wtotal <= 0) r.status = wrm_pkg::ST_ZERO;
            else r.status = wrm_pkg::ST_OK;
            if (r.status == wrm_pkg::ST_OK) begin
                sneg = wsum < 0;
                smag = sneg ? -wsum : wsum;
                q = smag / longint'(wtotal);
                // A negative sum of squares only arises after a mode change.
                if (mode) q = sneg ? 0 : int_root(q);
                if (q > 64'd32768) q = 64'd32768;
                r.mean = (sneg && !mode) ? -q[16:0] : q[16:0];
            end
            pending.push_back(r);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("MISMATCH %s: got %0d expected %0d (beat %0d)", what, got, want, checked);
        endtask

        task check_result(logic signed [16:0] mean, logic [1:0] status);
            t_mean_result e;
            if (pending.size() == 0) begin
                report("unexpected result", {15'd0, mean}, 0);
                return;
            end
            e = pending.pop_front();
            if (status !== e.status) report("mean_status", status, e.status);
            if (mean !== e.mean) report("running_mean", $signed(mean), $signed(e.mean));
            status_seen[e.status]++;
            checked++;
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_data = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic signed [15:0] i_sample_value = '0;
    logic signed [15:0] i_sample_weight = '0;
    logic full, empty;
    logic signed [16:0] o_running_mean;
    logic [1:0] o_mean_status;

    t_mean_scoreboard sb = new();
    int idle_cycles = 0;
    int mode_writes = 0;
    int stall_left = 0;
    int pop_style = 0;

    weighted_running_mean u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .push(push),
        .full(full),
        .i_sample_value(i_sample_value),
        .i_sample_weight(i_sample_weight),
        .empty(empty),
        .pop(pop),
        .o_running_mean(o_running_mean),
        .o_mean_status(o_mean_status)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Monitors sample pre-edge values; the receiver stall pattern changes style now and then.
    always @(posedge i_clk) begin
        if (push && !full) sb.note_input(i_sample_value, i_sample_weight);
        if (pop && !empty) sb.check_result(o_running_mean, o_mean_status);
        if (i_rst_n && !(push && !full) && !(pop && !empty)) idle_cycles <= idle_cycles + 1;
        else idle_cycles <= 0;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("weighted_running_mean test failed");
            $finish;
        end
        if ($urandom_range(0, 199) == 0) pop_style <= $urandom_range(0, 2);
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            pop <= 1'b0;
        end else if (pop_style == 1 && $urandom_range(0, 9) < 3) begin
            stall_left <= $urandom_range(0, 3);
            pop <= 1'b0;
        end else if (pop_style == 2 && $urandom_range(0, 19) == 0) begin
            stall_left <= $urandom_range(10, 60);
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    task send_beat(logic signed [15:0] v, logic signed [15:0] w);
        push <= 1'b1;
        i_sample_value <= v;
        i_sample_weight <= w;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    task pause_sender(int cycles);
        push <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task drain();
        pause_sender(1);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task write_mode(logic m);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.mode = m;
        mode_writes++;
    endtask

    task send_random(int count, int gappy);
        logic signed [15:0] v, w;
        int burst, sel;
        burst = 0;
        for (int n = 0; n < count; n++) begin
            if (burst == 0) begin
                if (gappy) pause_sender($urandom_range(1, 15));
                burst = $urandom_range(1, 20);
            end
            burst--;
            sel = $urandom_range(0, 19);
            v = 16'($urandom);
            if (sel == 0) v = 16'sh8000;
            else if (sel == 1) v = 16'sh7fff;
            w = 16'($urandom_range(0, 32767));
            sel = $urandom_range(0, 19);
            if (sel < 2) w = 16'sh8000 | 16'($urandom);
            else if (sel < 4) w = '0;
            else if (sel == 4) w = 16'sh7fff;
            else if (sel < 9) w = 16'($urandom_range(1, 512));
            send_beat(v, w);
            if (n == count / 2 && gappy) drain();
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_mode(1'b0);
        // Before any positive weight the total is zero; a negative weight leaves sums alone.
        send_beat(16'sh0100, 16'sh0000);
        send_beat(16'sh8000, 16'sh8000);
        send_beat(16'sh7fff, 16'shffff);
        send_beat(16'sh8000, 16'sh0100);
        send_beat(16'sh7fff, 16'sh7fff);
        send_beat(16'sh0000, 16'sh0001);
        send_beat(16'shff00, 16'sh7fff);
        send_beat(16'sh1234, 16'sh0000);
        send_beat(16'sh8000, 16'sh7fff);
        send_beat(16'sh8000, 16'sh7fff);
        write_mode(1'b1);
        // The sum enters negative, but the first square term already outweighs it.
        send_beat(16'sh8000, 16'sh7fff);
        send_beat(16'sh7fff, 16'sh7fff);
        send_beat(16'sh0001, 16'sh0001);
        send_beat(16'sh0100, 16'sh8001);
        send_beat(16'sh7fff, 16'sh7fff);
        send_beat(16'sh7fff, 16'sh7fff);
        write_mode(1'b0);
        // Squares read as plain products push the mean past the clamp.
        send_beat(16'sh0001, 16'sh0001);
        send_beat(16'sh0000, 16'sh0000);
        write_mode(1'b1);
        send_random(500, 1);
        write_mode(1'b0);
        send_random(500, 1);
        write_mode(1'b1);
        send_random(500, 0);
        write_mode(1'b0);
        send_random(500, 1);
        drain();
        $display("covered %0d beats over %0d mode writes; ok %0d, negative weight %0d,",
                 sb.checked, mode_writes, sb.status_seen[wrm_pkg::ST_OK],
                 sb.status_seen[wrm_pkg::ST_NEGW]);
        $display("zero total %0d, saturated %0d; %0d leftover expectations",
                 sb.status_seen[wrm_pkg::ST_ZERO], sb.status_seen[wrm_pkg::ST_SAT],
                 sb.pending.size());
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("weighted_running_mean test passed");
        end else begin
            $display("weighted_running_mean test failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
